### hw/rtl/adsa_pkg.sv
// Shared types, constants and helpers for the ASCII decimal string adder.
package adsa_pkg;

    localparam logic [7:0] DIGIT_ZERO = 8'd48;
    localparam logic [7:0] DIGIT_NINE = 8'd57;
    localparam logic [4:0] RADIX      = 5'd10;

    // Quotient of a 32-bit value by ten fits in 29 bits.
    localparam int QUOT_W = 29;
    localparam logic [31:0] RECIP_TEN = 32'hCCCC_CCCD;

    localparam logic [1:0] STATUS_OK        = 2'd0;
    localparam logic [1:0] STATUS_NO_DIGITS = 2'd1;
    localparam logic [1:0] STATUS_NEG_WRAP  = 2'd2;

    typedef struct packed {
        logic [7:0]         char_in;
        logic signed [31:0] amount;
        logic               first_item;
        logic               last_item;
    } item_t;

    typedef struct packed {
        logic [7:0] char_out;
        logic [1:0] status;
        logic       last_out;
    } result_t;

    typedef struct packed {
        logic [31:0] remainder;
        logic        subtracting;
        logic        seen_digit;
    } acc_state_t;

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= DIGIT_ZERO) && (c <= DIGIT_NINE);
    endfunction

endpackage

### hw/rtl/adsa_div10.sv
// Divide a 32-bit value by ten with a reciprocal multiply.
module adsa_div10
(
    input  logic [31:0]                  value,
    output logic [adsa_pkg::QUOT_W-1:0]  quotient,
    output logic [3:0]                   low_digit
);

    logic [63:0] product;
    logic [3:0]  tens_low;

    always_comb
    begin
        product  = {32'b0, value} * {32'b0, adsa_pkg::RECIP_TEN};
        quotient = product[63:35];
        // The remainder is below ten, so only the low nibbles matter.
        tens_low  = {quotient[0], 3'b000} + {quotient[2:0], 1'b0};
        low_digit = value[3:0] - tens_low;
    end

endmodule

### hw/rtl/adsa_step.sv
// Per-character update of the running remainder and the digit.
module adsa_step
(
    input  adsa_pkg::item_t      item,
    input  adsa_pkg::acc_state_t state_cur,
    output adsa_pkg::result_t    result,
    output adsa_pkg::acc_state_t state_nxt
);

    adsa_pkg::acc_state_t             start;
    logic [31:0]                      neg_amount;
    logic [adsa_pkg::QUOT_W-1:0]      quotient;
    logic [3:0]                       low_digit;
    logic [3:0]                       in_digit;
    logic [4:0]                       work;
    logic [3:0]                       new_digit;
    logic                             carry;
    logic                             digit_hit;

    always_comb
    begin
        neg_amount = 32'd0 - item.amount;
        if (item.first_item)
        begin
            start.subtracting = item.amount[31];
            start.remainder   = item.amount[31] ? neg_amount : item.amount;
            start.seen_digit  = 1'b0;
        end
        else
        begin
            start = state_cur;
        end
    end

    adsa_div10 u_div10
    (
        .value     (start.remainder),
        .quotient  (quotient),
        .low_digit (low_digit)
    );

    always_comb
    begin
        digit_hit = adsa_pkg::is_digit(item.char_in);
        in_digit  = item.char_in[3:0];
        carry     = 1'b0;
        work      = 5'd0;
        if (start.subtracting)
        begin
            if (in_digit < low_digit)
            begin
                work  = {1'b0, in_digit} + adsa_pkg::RADIX - {1'b0, low_digit};
                carry = 1'b1;
            end
            else
            begin
                work = {1'b0, in_digit} - {1'b0, low_digit};
            end
        end
        else
        begin
            work = {1'b0, in_digit} + {1'b0, low_digit};
            if (work >= adsa_pkg::RADIX)
            begin
                work  = work - adsa_pkg::RADIX;
                carry = 1'b1;
            end
        end
        new_digit = work[3:0];

        state_nxt.subtracting = start.subtracting;
        state_nxt.seen_digit  = start.seen_digit | digit_hit;
        if (digit_hit)
        begin
            state_nxt.remainder = {{(32 - adsa_pkg::QUOT_W){1'b0}}, quotient}
                                  + {31'b0, carry};
            result.char_out     = adsa_pkg::DIGIT_ZERO + {4'b0, new_digit};
        end
        else
        begin
            state_nxt.remainder = start.remainder;
            result.char_out     = item.char_in;
        end

        result.last_out = item.last_item;
        if (!item.last_item)
            result.status = adsa_pkg::STATUS_OK;
        else if (state_nxt.subtracting && (state_nxt.remainder != 32'd0))
            result.status = adsa_pkg::STATUS_NEG_WRAP;
        else if (state_nxt.seen_digit)
            result.status = adsa_pkg::STATUS_OK;
        else
            result.status = adsa_pkg::STATUS_NO_DIGITS;
    end

endmodule

### hw/rtl/ascii_decimal_string_add_top.sv
// An accepted item is held in item_reg, then its result in result_reg until it is taken.
// Throughput: one character per cycle if result_ready is high, no gaps between strings.
// The rate is set by the remainder loop: one reciprocal multiply for the divide
// by ten and a digit add or subtract, computed combinationally from state_reg.
// Reset clears both stage valid flags and the remainder, sign and digit-seen state.
// Top level of the ASCII decimal string adder.
module ascii_decimal_string_add_top
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              item_valid,
    output logic              item_ready,
    input  adsa_pkg::item_t   item,
    output logic              result_valid,
    input  logic              result_ready,
    output adsa_pkg::result_t result
);

    adsa_pkg::item_t      item_reg;
    logic                 item_valid_reg;
    adsa_pkg::result_t    result_reg;
    logic                 result_valid_reg;
    adsa_pkg::acc_state_t state_reg;
    adsa_pkg::acc_state_t state_next;
    adsa_pkg::result_t    result_next;
    logic                 advance;

    // The held item moves on whenever the result register is free or draining.
    assign advance    = item_valid_reg && (!result_valid_reg || result_ready);
    assign item_ready = !item_valid_reg || advance;

    adsa_step u_step
    (
        .item      (item_reg),
        .state_cur (state_reg),
        .result    (result_next),
        .state_nxt (state_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg   <= 1'b0;
            result_valid_reg <= 1'b0;
            state_reg        <= '0;
        end
        else
        begin
            if (item_ready)
                item_valid_reg <= item_valid;
            if (advance)
            begin
                result_valid_reg <= 1'b1;
                state_reg        <= state_next;
            end
            else if (result_ready)
            begin
                result_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_ready && item_valid)
            item_reg <= item;
        if (advance)
            result_reg <= result_next;
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    // Status is only reported on the transfer that ends a string.
    a_status_only_on_last: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid_reg && !result_reg.last_out)
            |-> (result_reg.status == adsa_pkg::STATUS_OK))
        else $error("status set on a result that does not end the string");

    // Negative wrap can only come from a subtraction.
    a_wrap_needs_sub: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid_reg && result_reg.last_out
            && (result_reg.status == adsa_pkg::STATUS_NEG_WRAP))
            |-> state_reg.subtracting)
        else $error("negative wrap reported while adding");

    // Non-digit characters pass through unchanged.
    a_passthrough: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && !adsa_pkg::is_digit(item_reg.char_in))
            |=> (result_reg.char_out == $past(item_reg.char_in)))
        else $error("non-digit character was modified");

    // A digit stays a digit, so the last character cannot be a digit on no-digits status.
    a_no_digits: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid_reg && result_reg.last_out
            && (result_reg.status == adsa_pkg::STATUS_NO_DIGITS))
            |-> !adsa_pkg::is_digit(result_reg.char_out))
        else $error("no-digits status with a digit in the result");

endmodule

### dv/ascii_decimal_string_add_top_tb.sv
// Self-checking testbench for the ASCII decimal string adder top level.
`timescale 1ns / 1ps

module ascii_decimal_string_add_top_tb;

    typedef struct {
        adsa_pkg::item_t   it;
        bit                pinned;
        adsa_pkg::result_t want;
    } dir_row_t;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              item_valid = 1'b0;
    logic              item_ready;
    adsa_pkg::item_t   item = '0;
    logic              result_valid;
    logic              result_ready = 1'b0;
    adsa_pkg::result_t result;

    // Running state of the digit adder as the testbench sees it.
    logic [31:0] rem_left = '0;
    logic        neg_mode = 1'b0;
    logic        digit_seen = 1'b0;

    adsa_pkg::result_t pending_results[$];
    dir_row_t          dir_rows[$];
    int                mismatches = 0;
    int                items_sent = 0;
    int unsigned       send_idle_pct = 0;
    int unsigned       stall_pct = 0;
    bit                hold_request = 1'b0;
    int                hold_cycles = 0;

    ascii_decimal_string_add_top dut
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .item         (item),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

    always #1 clk = ~clk;

    initial
    begin
        #2_000_000;
        $display("ascii_decimal_string_add_top_tb: done, errors");
        $finish;
    end

    // Applies one character to the running remainder and returns its result.
    function automatic adsa_pkg::result_t add_to_char(input adsa_pkg::item_t it);
        logic [4:0]        d;
        logic [3:0]        low;
        adsa_pkg::result_t r;
        if (it.first_item)
        begin
            neg_mode   = it.amount[31];
            rem_left   = it.amount[31] ? 32'd0 - it.amount : it.amount;
            digit_seen = 1'b0;
        end
        r.char_out = it.char_in;
        r.status   = adsa_pkg::STATUS_OK;
        r.last_out = it.last_item;
        if (it.char_in >= adsa_pkg::DIGIT_ZERO && it.char_in <= adsa_pkg::DIGIT_NINE)
        begin
            d        = 5'(it.char_in - adsa_pkg::DIGIT_ZERO);
            low      = 4'(rem_left % 32'(adsa_pkg::RADIX));
            rem_left = rem_left / 32'(adsa_pkg::RADIX);
            if (neg_mode)
            begin
                if (d < 5'(low))
                begin
                    d        = d + adsa_pkg::RADIX - 5'(low);
                    rem_left = rem_left + 32'd1;
                end
                else
                begin
                    d = d - 5'(low);
                end
            end
            else
            begin
                d = d + 5'(low);
                if (d >= adsa_pkg::RADIX)
                begin
                    d        = d - adsa_pkg::RADIX;
                    rem_left = rem_left + 32'd1;
                end
            end
            r.char_out = adsa_pkg::DIGIT_ZERO + 8'(d);
            digit_seen = 1'b1;
        end
        if (it.last_item)
        begin
            if (neg_mode && rem_left != 32'd0)
                r.status = adsa_pkg::STATUS_NEG_WRAP;
            else if (digit_seen)
                r.status = adsa_pkg::STATUS_OK;
            else
                r.status = adsa_pkg::STATUS_NO_DIGITS;
        end
        return r;
    endfunction

    function automatic void add_row(input logic [7:0] c, input logic [31:0] amt,
                                    input bit first, input bit last, input bit pinned,
                                    input logic [7:0] want_char, input logic [1:0] want_status);
        dir_row_t row;
        row.it.char_in    = c;
        row.it.amount     = amt;
        row.it.first_item = first;
        row.it.last_item  = last;
        row.pinned        = pinned;
        row.want.char_out = want_char;
        row.want.status   = want_status;
        row.want.last_out = last;
        dir_rows.push_back(row);
    endfunction

    function automatic logic [7:0] random_char();
        if ($urandom_range(3) != 0)
            return adsa_pkg::DIGIT_ZERO + 8'($urandom_range(9));
        return 8'($urandom_range(255));
    endfunction

    function automatic logic [31:0] random_amount();
        unique case ($urandom_range(5))
            0: return 32'($urandom_range(99));
            1: return 32'd0 - 32'($urandom_range(99));
            2: return 32'($urandom_range(999999));
            3: return 32'd0 - 32'($urandom_range(999999));
            4:
            begin
                unique case ($urandom_range(3))
                    0: return 32'h7FFF_FFFF;
                    1: return 32'h8000_0000;
                    2: return 32'hFFFF_FFFF;
                    default: return 32'd0;
                endcase
            end
            default: return $urandom;
        endcase
    endfunction

    // Called just after a falling edge; returns just after the falling edge
    // that follows the transfer, so the next call can present at once.
    task automatic send_item(input adsa_pkg::item_t it, input bit pinned,
                             input adsa_pkg::result_t want);
        adsa_pkg::result_t predicted;
        while ($urandom_range(99) < send_idle_pct)
        begin
            item_valid <= 1'b0;
            @(negedge clk);
        end
        item_valid <= 1'b1;
        item       <= it;
        @(posedge clk);
        while (!item_ready)
            @(posedge clk);
        predicted = add_to_char(it);
        pending_results.push_back(pinned ? want : predicted);
        items_sent++;
        @(negedge clk);
    endtask

    task automatic send_string(input int len, input logic [31:0] amt);
        adsa_pkg::item_t it;
        for (int i = 0; i < len; i++)
        begin
            it.char_in    = random_char();
            it.amount     = (i == 0) ? amt : $urandom;
            it.first_item = (i == 0);
            it.last_item  = (i == len - 1);
            send_item(it, 1'b0, '0);
        end
    endtask

    // Receiver: random stalls, plus a long hold-off on request.
    initial
    begin
        forever
        begin
            @(negedge clk);
            if (hold_request)
            begin
                hold_cycles  = 60;
                hold_request = 1'b0;
            end
            if (hold_cycles > 0)
            begin
                result_ready <= 1'b0;
                hold_cycles  = hold_cycles - 1;
            end
            else
            begin
                result_ready <= ($urandom_range(99) >= stall_pct);
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && result_valid && result_ready)
        begin
            if (pending_results.size() == 0)
            begin
                $error("unexpected result transfer: char_out %0h", result.char_out);
                mismatches++;
            end
            else
            begin
                adsa_pkg::result_t want;
                want = pending_results.pop_front();
                if (result.char_out !== want.char_out)
                begin
                    $error("char_out: expected %0h, got %0h", want.char_out, result.char_out);
                    mismatches++;
                end
                if (result.status !== want.status)
                begin
                    $error("status: expected %0d, got %0d", want.status, result.status);
                    mismatches++;
                end
                if (result.last_out !== want.last_out)
                begin
                    $error("last_out: expected %0d, got %0d", want.last_out, result.last_out);
                    mismatches++;
                end
            end
        end
    end

    initial
    begin
        adsa_pkg::item_t noise;
        int              phase_goal;

        // Digit with no start right after reset: zero remainder leaves it alone.
        add_row("7", 32'd0, 1'b0, 1'b1, 1'b1, "7", adsa_pkg::STATUS_OK);
        add_row("a", 32'd5, 1'b1, 1'b1, 1'b1, "a", adsa_pkg::STATUS_NO_DIGITS);
        add_row("0", 32'hFFFF_FFFF, 1'b1, 1'b1, 1'b1, "9", adsa_pkg::STATUS_NEG_WRAP);
        add_row(8'hFF, 32'h8000_0000, 1'b1, 1'b1, 1'b1, 8'hFF, adsa_pkg::STATUS_NEG_WRAP);
        // Positive overflow past the leftmost digit is dropped.
        add_row("9", 32'h7FFF_FFFF, 1'b1, 1'b1, 1'b1, "6", adsa_pkg::STATUS_OK);
        add_row(8'h00, 32'd0, 1'b1, 1'b1, 1'b1, 8'h00, adsa_pkg::STATUS_NO_DIGITS);
        add_row("/", 32'd3, 1'b1, 1'b1, 1'b1, "/", adsa_pkg::STATUS_NO_DIGITS);
        add_row(":", 32'd3, 1'b1, 1'b1, 1'b1, ":", adsa_pkg::STATUS_NO_DIGITS);
        // Carry ripple through nines, then borrow ripple through zeros.
        add_row("9", 32'd1, 1'b1, 1'b0, 1'b0, 8'h00, adsa_pkg::STATUS_OK);
        add_row("9", 32'd0, 1'b0, 1'b0, 1'b0, 8'h00, adsa_pkg::STATUS_OK);
        add_row("9", 32'd0, 1'b0, 1'b0, 1'b0, 8'h00, adsa_pkg::STATUS_OK);
        add_row("1", 32'd0, 1'b0, 1'b1, 1'b0, 8'h00, adsa_pkg::STATUS_OK);
        add_row("0", 32'hFFFF_FFFF, 1'b1, 1'b0, 1'b0, 8'h00, adsa_pkg::STATUS_OK);
        add_row("0", 32'd0, 1'b0, 1'b0, 1'b0, 8'h00, adsa_pkg::STATUS_OK);
        add_row("0", 32'd0, 1'b0, 1'b0, 1'b0, 8'h00, adsa_pkg::STATUS_OK);
        add_row("1", 32'd0, 1'b0, 1'b1, 1'b0, 8'h00, adsa_pkg::STATUS_OK);
        add_row("5", 32'd0, 1'b0, 1'b1, 1'b0, 8'h00, adsa_pkg::STATUS_OK);
        add_row("8", 32'h8000_0000, 1'b1, 1'b0, 1'b0, 8'h00, adsa_pkg::STATUS_OK);
        add_row("4", 32'd0, 1'b0, 1'b1, 1'b0, 8'h00, adsa_pkg::STATUS_OK);
        add_row("5", 32'h7FFF_FFFF, 1'b1, 1'b0, 1'b0, 8'h00, adsa_pkg::STATUS_OK);
        add_row(".", 32'h7FFF_FFFF, 1'b0, 1'b0, 1'b0, 8'h00, adsa_pkg::STATUS_OK);
        add_row(8'h80, 32'h8000_0000, 1'b0, 1'b0, 1'b0, 8'h00, adsa_pkg::STATUS_OK);
        add_row("1", 32'hFFFF_FFFF, 1'b0, 1'b1, 1'b0, 8'h00, adsa_pkg::STATUS_OK);

        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (dir_rows[i])
            send_item(dir_rows[i].it, dir_rows[i].pinned, dir_rows[i].want);

        phase_goal = items_sent;
        for (int phase = 0; phase < 4; phase++)
        begin
            unique case (phase)
                0:
                begin
                    send_idle_pct = 0;
                    stall_pct     = 0;
                end
                1:
                begin
                    send_idle_pct = 83;
                    stall_pct     = 0;
                end
                2:
                begin
                    send_idle_pct = 0;
                    stall_pct     = 83;
                end
                default:
                begin
                    send_idle_pct = 17;
                    stall_pct     = 17;
                end
            endcase
            phase_goal += 175;
            if (phase == 0)
            begin
                // The receiver holds off while a long string keeps coming, so
                // the block fills and has to stall its input.
                hold_request = 1'b1;
                send_string(90, random_amount());
            end
            while (items_sent < phase_goal)
            begin
                if ($urandom_range(9) == 0)
                begin
                    noise.char_in    = 8'($urandom_range(255));
                    noise.amount     = $urandom;
                    noise.first_item = 1'($urandom_range(1));
                    noise.last_item  = 1'($urandom_range(1));
                    send_item(noise, 1'b0, '0);
                end
                else if ($urandom_range(7) == 0)
                begin
                    send_string($urandom_range(13, 24), random_amount());
                end
                else
                begin
                    send_string($urandom_range(1, 12), random_amount());
                end
            end
        end

        item_valid <= 1'b0;
        stall_pct = 0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
        if (mismatches == 0)
            $display("ascii_decimal_string_add_top_tb: done, clean");
        else
            $display("ascii_decimal_string_add_top_tb: done, errors");
        $finish;
    end

endmodule
